/* src/top_k_sorted_store_core_macros.svh */
// Assertion macros for the top-k sorted store core.
// Depends on a clock named clk and an active-low reset named arst_n in the using scope.
`ifndef TOP_K_SORTED_STORE_CORE_MACROS_SVH
`define TOP_K_SORTED_STORE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define TKS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed in top_k_sorted_store_core");
// Next-cycle implication.
`define TKS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed in top_k_sorted_store_core");
`else
`define TKS_ASSERT_NOW(lbl, ante, cons)
`define TKS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* src/tks_pkg.sv */
// Shared types and constants of the top-k sorted store.
// No dependencies; used by tks_cell and top_k_sorted_store_core.
`default_nettype none
package tks_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int OBJ_BITS    = 32;
	localparam int PAY_BITS    = 16;
	localparam int IDX_BITS    = 4;
	localparam int CNT_BITS    = 5;
	localparam int STATUS_BITS = 4;

	localparam logic [CNT_BITS-1:0] CAP_RESET = CNT_BITS'(16);

	typedef enum logic [1:0] {
		FN_INS_REPLACE = 2'd0,
		FN_INS_KEEP    = 2'd1,
		FN_DELETE      = 2'd2,
		FN_READ        = 2'd3
	} func_t;

	typedef enum logic [STATUS_BITS-1:0] {
		ST_INSERTED      = 4'd0,
		ST_REPLACED      = 4'd1,
		ST_TIE_REJECTED  = 4'd2,
		ST_FULL_REJECTED = 4'd3,
		ST_SENTINEL      = 4'd4,
		ST_DELETED       = 4'd5,
		ST_NO_ENTRY      = 4'd6,
		ST_READ_OK       = 4'd7,
		ST_EMPTY         = 4'd8
	} status_t;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INSERT,
		CELL_REPLACE,
		CELL_DELETE
	} cell_cmd_t;

	typedef struct packed {
		cell_cmd_t             cmd;
		logic [IDX_BITS-1:0]   del_pos;
		logic [CNT_BITS-1:0]   count;
	} cell_ctrl_t;

endpackage
`default_nettype wire

/* src/tks_cell.sv */
// One slot of the sorted store: holds an entry, compares it with the incoming objective
// and shifts to or from its neighbors. Depends on tks_pkg.
`default_nettype none
module tks_cell (
	input  wire logic                          clk,
	input  wire tks_pkg::cell_ctrl_t           ctrl,
	input  wire logic [tks_pkg::IDX_BITS-1:0]  cell_index,
	input  wire logic [tks_pkg::OBJ_BITS-1:0]  new_obj,
	input  wire logic [tks_pkg::PAY_BITS-1:0]  new_pay,
	input  wire logic                          left_lt,
	input  wire logic [tks_pkg::OBJ_BITS-1:0]  left_obj,
	input  wire logic [tks_pkg::PAY_BITS-1:0]  left_pay,
	input  wire logic [tks_pkg::OBJ_BITS-1:0]  right_obj,
	input  wire logic [tks_pkg::PAY_BITS-1:0]  right_pay,
	output logic [tks_pkg::OBJ_BITS-1:0]       obj,
	output logic [tks_pkg::PAY_BITS-1:0]       pay,
	output logic                               lt,
	output logic                               eq
);

	logic [tks_pkg::OBJ_BITS-1:0] obj_q;
	logic [tks_pkg::PAY_BITS-1:0] pay_q;
	logic                         valid;
	logic                         at_pos;

	assign valid  = {1'b0, cell_index} < ctrl.count;
	assign lt     = valid && (obj_q < new_obj);
	// The store is sorted, so the insert point is the first cell that is not below.
	assign at_pos = !lt && left_lt;
	assign eq     = at_pos && valid && (obj_q == new_obj);
	assign obj    = obj_q;
	assign pay    = pay_q;

	always_ff @(posedge clk) begin
		case (ctrl.cmd)
			tks_pkg::CELL_INSERT: begin
				if (!lt) begin
					if (left_lt) begin
						obj_q <= new_obj;
						pay_q <= new_pay;
					end else begin
						obj_q <= left_obj;
						pay_q <= left_pay;
					end
				end
			end
			tks_pkg::CELL_REPLACE: begin
				if (at_pos) begin
					pay_q <= new_pay;
				end
			end
			tks_pkg::CELL_DELETE: begin
				if (cell_index >= ctrl.del_pos) begin
					obj_q <= right_obj;
					pay_q <= right_pay;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
`default_nettype wire

/* src/top_k_sorted_store_core.sv */
// Top-k sorted store: a row of compare-and-shift cells plus operation control.
// The result is registered at the accepting edge and offered in the next cycle.
// Throughput is one item per cycle while results are taken; every cell compares in parallel.
// Reset clears the entry count and sets capacity to 16; entry contents are not cleared.
// Depends on tks_pkg, tks_cell and top_k_sorted_store_core_macros.svh.
`default_nettype none
`include "top_k_sorted_store_core_macros.svh"
module top_k_sorted_store_core (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [1:0]                       func,
	input  wire logic [tks_pkg::OBJ_BITS-1:0]     new_objective,
	input  wire logic [tks_pkg::PAY_BITS-1:0]     new_payload,
	input  wire logic [tks_pkg::IDX_BITS-1:0]     slot_index,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [tks_pkg::STATUS_BITS-1:0]       status,
	output logic [tks_pkg::CNT_BITS-1:0]          position,
	output logic [tks_pkg::CNT_BITS-1:0]          entry_count,
	output logic [tks_pkg::OBJ_BITS-1:0]          read_objective,
	output logic [tks_pkg::PAY_BITS-1:0]          read_payload,
	input  wire logic                             cfg_we,
	input  wire logic [tks_pkg::CNT_BITS-1:0]     cfg_wdata
);

	logic [tks_pkg::OBJ_BITS-1:0] obj_arr [tks_pkg::MAX_ENTRIES];
	logic [tks_pkg::PAY_BITS-1:0] pay_arr [tks_pkg::MAX_ENTRIES];
	logic [tks_pkg::MAX_ENTRIES-1:0] lt_vec;
	logic [tks_pkg::MAX_ENTRIES-1:0] eq_vec;

	logic [tks_pkg::CNT_BITS-1:0] count_q;
	logic [tks_pkg::CNT_BITS-1:0] capacity_q;
	logic                         out_valid_q;
	tks_pkg::status_t             status_q;
	logic [tks_pkg::CNT_BITS-1:0] position_q;
	logic [tks_pkg::OBJ_BITS-1:0] robj_q;
	logic [tks_pkg::PAY_BITS-1:0] rpay_q;

	logic                         acc;
	logic [tks_pkg::CNT_BITS-1:0] cap;
	logic [tks_pkg::CNT_BITS-1:0] ins_pos;
	logic [tks_pkg::IDX_BITS-1:0] slot_pos;
	logic                         tie;
	logic [tks_pkg::OBJ_BITS-1:0] rd_obj;
	logic [tks_pkg::PAY_BITS-1:0] rd_pay;
	tks_pkg::cell_cmd_t           cmd;
	tks_pkg::cell_ctrl_t          ctrl;
	tks_pkg::status_t             res_status;
	logic [tks_pkg::CNT_BITS-1:0] res_pos;
	logic [tks_pkg::CNT_BITS-1:0] cnt_nxt;
	logic [tks_pkg::OBJ_BITS-1:0] res_obj;
	logic [tks_pkg::PAY_BITS-1:0] res_pay;
	logic [tks_pkg::CNT_BITS:0]   count_inc;

	assign in_ready = !out_valid_q || out_ready;
	assign acc      = in_valid && in_ready;
	assign cap      = (capacity_q > tks_pkg::CNT_BITS'(tks_pkg::MAX_ENTRIES))
		? tks_pkg::CNT_BITS'(tks_pkg::MAX_ENTRIES) : capacity_q;

	generate
		for (genvar i = 0; i < tks_pkg::MAX_ENTRIES; i++) begin : g_cell
			logic                         l_lt;
			logic [tks_pkg::OBJ_BITS-1:0] l_obj;
			logic [tks_pkg::PAY_BITS-1:0] l_pay;
			logic [tks_pkg::OBJ_BITS-1:0] r_obj;
			logic [tks_pkg::PAY_BITS-1:0] r_pay;
			if (i == 0) begin : g_first
				assign l_lt  = 1'b1;
				assign l_obj = '0;
				assign l_pay = '0;
			end else begin : g_mid
				assign l_lt  = lt_vec[i-1];
				assign l_obj = obj_arr[i-1];
				assign l_pay = pay_arr[i-1];
			end
			// The last cell pulls its own contents on delete; that slot falls out of the count.
			if (i == tks_pkg::MAX_ENTRIES - 1) begin : g_last
				assign r_obj = obj_arr[i];
				assign r_pay = pay_arr[i];
			end else begin : g_inner
				assign r_obj = obj_arr[i+1];
				assign r_pay = pay_arr[i+1];
			end
			tks_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.cell_index(tks_pkg::IDX_BITS'(i)),
				.new_obj   (new_objective),
				.new_pay   (new_payload),
				.left_lt   (l_lt),
				.left_obj  (l_obj),
				.left_pay  (l_pay),
				.right_obj (r_obj),
				.right_pay (r_pay),
				.obj       (obj_arr[i]),
				.pay       (pay_arr[i]),
				.lt        (lt_vec[i]),
				.eq        (eq_vec[i])
			);
		end
	endgenerate

	always_comb begin
		ins_pos = tks_pkg::CNT_BITS'(tks_pkg::MAX_ENTRIES);
		for (int i = tks_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
			if (!lt_vec[i]) begin
				ins_pos = tks_pkg::CNT_BITS'(i);
			end
		end
		tie = (ins_pos < count_q) && (|eq_vec);
		if ({1'b0, slot_index} < count_q) begin
			slot_pos = slot_index;
		end else begin
			slot_pos = tks_pkg::IDX_BITS'(count_q - 1'b1);
		end
		rd_obj = '0;
		rd_pay = '0;
		for (int i = 0; i < tks_pkg::MAX_ENTRIES; i++) begin
			if (tks_pkg::IDX_BITS'(i) == slot_pos) begin
				rd_obj = obj_arr[i];
				rd_pay = pay_arr[i];
			end
		end
	end

	always_comb begin
		cmd        = tks_pkg::CELL_HOLD;
		res_status = tks_pkg::ST_INSERTED;
		res_pos    = '0;
		cnt_nxt    = count_q;
		res_obj    = '0;
		res_pay    = '0;
		count_inc  = {1'b0, count_q} + 1'b1;
		case (tks_pkg::func_t'(func))
			tks_pkg::FN_INS_REPLACE, tks_pkg::FN_INS_KEEP: begin
				if ((tks_pkg::func_t'(func) == tks_pkg::FN_INS_REPLACE) && (&new_objective)) begin
					res_status = tks_pkg::ST_SENTINEL;
				end else if ((ins_pos == count_q) && (count_q >= cap)) begin
					res_status = tks_pkg::ST_FULL_REJECTED;
				end else if (ins_pos >= cap) begin
					// Capacity was lowered below the count; the insert would fall off the end.
					res_status = tks_pkg::ST_FULL_REJECTED;
					cnt_nxt    = cap;
				end else if (tie) begin
					res_pos = ins_pos;
					if (tks_pkg::func_t'(func) == tks_pkg::FN_INS_REPLACE) begin
						res_status = tks_pkg::ST_REPLACED;
						cmd        = tks_pkg::CELL_REPLACE;
					end else begin
						res_status = tks_pkg::ST_TIE_REJECTED;
					end
					if (count_q > cap) begin
						cnt_nxt = cap;
					end
				end else begin
					cmd        = tks_pkg::CELL_INSERT;
					res_status = tks_pkg::ST_INSERTED;
					res_pos    = ins_pos;
					cnt_nxt    = (count_inc < {1'b0, cap})
						? tks_pkg::CNT_BITS'(count_inc) : cap;
				end
			end
			tks_pkg::FN_DELETE, tks_pkg::FN_READ: begin
				if (count_q == '0) begin
					res_status = (tks_pkg::func_t'(func) == tks_pkg::FN_DELETE)
						? tks_pkg::ST_NO_ENTRY : tks_pkg::ST_EMPTY;
				end else begin
					res_pos = {1'b0, slot_pos};
					if (tks_pkg::func_t'(func) == tks_pkg::FN_DELETE) begin
						cmd        = tks_pkg::CELL_DELETE;
						res_status = tks_pkg::ST_DELETED;
						cnt_nxt    = count_q - 1'b1;
					end else begin
						res_status = tks_pkg::ST_READ_OK;
						res_obj    = rd_obj;
						res_pay    = rd_pay;
					end
				end
			end
			default: begin
			end
		endcase
		ctrl.cmd     = acc ? cmd : tks_pkg::CELL_HOLD;
		ctrl.del_pos = slot_pos;
		ctrl.count   = count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			capacity_q  <= tks_pkg::CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (acc) begin
				count_q     <= cnt_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			status_q   <= res_status;
			position_q <= res_pos;
			robj_q     <= res_obj;
			rpay_q     <= res_pay;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign position       = position_q;
	assign entry_count    = count_q;
	assign read_objective = robj_q;
	assign read_payload   = rpay_q;

	`TKS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= tks_pkg::CNT_BITS'(tks_pkg::MAX_ENTRIES))
	`TKS_ASSERT_NOW(a_stall_blocks_input, out_valid_q && !out_ready, !in_ready)
	`TKS_ASSERT_NEXT(a_insert_nonempty, acc && res_status == tks_pkg::ST_INSERTED, count_q != '0)
	`TKS_ASSERT_NEXT(a_delete_dec, acc && res_status == tks_pkg::ST_DELETED, count_q == tks_pkg::CNT_BITS'($past(count_q) - 1'b1))

endmodule
`default_nettype wire
